### rtl/core/ssel_pkg.sv
// Shared types and constants for the scanline sprite selector.
// No dependencies; imported by every module in rtl/core.
package ssel_pkg;

	// Operation codes carried on the op field
	typedef logic [1:0] op_t;
	localparam op_t OP_START = 2'd0;
	localparam op_t OP_OFFER = 2'd1;
	localparam op_t OP_READ  = 2'd2;

	// Vertical offset of sprite_y and the two sprite heights
	localparam int unsigned LINE_OFFSET = 16;
	localparam int unsigned SHORT_H     = 8;
	localparam int unsigned TALL_H      = 16;

	// One held object: 38 bits
	typedef struct packed {
		logic [7:0] y;
		logic [7:0] x;
		logic [7:0] tile;
		logic [7:0] flags;
		logic [5:0] index;
	} entry_t;

	// Controller commands to the datapath
	typedef struct packed {
		logic load_in;	// capture the input transfer
		logic exec;	// carry out the op and load the result register
	} ssel_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

### rtl/core/ssel_ctrl.sv
// Controller for the scanline sprite selector: sequences one item at a time.
// Depends on ssel_pkg.
module ssel_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output ssel_pkg::ssel_cmd_t cmd
);
	import ssel_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.load_in = 1'b0;
		cmd.exec    = 1'b0;
		out_valid_d = out_valid_q && out_stall;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// proceed only once the result register is free or draining
				if (!out_valid_q || !out_stall) begin
					cmd.exec    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

### rtl/core/ssel_dp.sv
// Datapath for the scanline sprite selector: sorted entry row, line state,
// visibility test and result register. Depends on ssel_pkg.
module ssel_dp #(
	parameter int unsigned MAX_SPRITES = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ssel_pkg::ssel_cmd_t cmd,
	input  logic                tall_sprites,
	input  logic [1:0]          op,
	input  logic [7:0]          line,
	input  logic [7:0]          sprite_y,
	input  logic [7:0]          sprite_x,
	input  logic [7:0]          sprite_tile,
	input  logic [7:0]          sprite_flags,
	input  logic [5:0]          oam_index,
	input  logic [3:0]          slot,
	output logic                accepted,
	output logic [3:0]          position,
	output logic [3:0]          count,
	output logic                read_valid,
	output logic [7:0]          read_y,
	output logic [7:0]          read_x,
	output logic [7:0]          read_tile,
	output logic [7:0]          read_flags,
	output logic [5:0]          read_index
);
	import ssel_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_SPRITES + 1);
	localparam int unsigned IDX_W = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;

	// Captured input transfer
	op_t        op_q;
	logic [7:0] line_q;
	entry_t     entry_q;
	logic [3:0] slot_q;

	// Line state
	logic [7:0]       cur_line_q;
	logic [CNT_W-1:0] held_q;
	entry_t           store_q [MAX_SPRITES];

	// Result register
	logic       accepted_q;
	logic [3:0] position_q;
	logic [3:0] count_q;
	logic       read_valid_q;
	entry_t     read_q;

	logic [MAX_SPRITES-1:0] le;
	logic [MAX_SPRITES-1:0] boundary;
	logic [IDX_W-1:0]       pos;
	logic [8:0]             line_pos;
	logic [8:0]             y_ext;
	logic [8:0]             y_end;
	logic                   covers;
	logic                   take;
	logic                   rd_ok;
	logic [CNT_W-1:0]       held_d;
	logic [4:0]             held_ext;
	entry_t                 rd_entry;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q          <= op;
			line_q        <= line;
			entry_q.y     <= sprite_y;
			entry_q.x     <= sprite_x;
			entry_q.tile  <= sprite_tile;
			entry_q.flags <= sprite_flags;
			entry_q.index <= oam_index;
			slot_q        <= slot;
		end
	end

	// Held entries below the insertion point have x not above the new x
	always_comb begin
		for (int i = 0; i < MAX_SPRITES; i++) begin
			le[i] = (CNT_W'(i) < held_q) && (store_q[i].x <= entry_q.x);
		end
		boundary[0] = !le[0];
		for (int i = 1; i < MAX_SPRITES; i++) begin
			boundary[i] = le[i-1] && !le[i];
		end
		pos = '0;
		for (int i = 0; i < MAX_SPRITES; i++) begin
			if (boundary[i]) begin
				pos = pos | IDX_W'(i);
			end
		end
	end

	// Visibility without wrap: y <= line + 16 < y + height
	assign line_pos = {1'b0, cur_line_q} + 9'(LINE_OFFSET);
	assign y_ext    = {1'b0, entry_q.y};
	assign y_end    = y_ext + (tall_sprites ? 9'(TALL_H) : 9'(SHORT_H));
	assign covers   = (y_ext <= line_pos) && (line_pos < y_end);

	assign take = (op_q == OP_OFFER) && (entry_q.x != 8'd0)
		&& (held_q < CNT_W'(MAX_SPRITES)) && covers;

	assign rd_ok = (op_q == OP_READ) && ({1'b0, slot_q} < 5'(held_q))
		&& ({1'b0, slot_q} < 5'(MAX_SPRITES));
	assign rd_entry = rd_ok ? store_q[slot_q[IDX_W-1:0]] : '0;

	always_comb begin
		held_d = held_q;
		case (op_q)
			OP_START: held_d = '0;
			OP_OFFER: begin
				if (take) begin
					held_d = held_q + CNT_W'(1);
				end
			end
			default: held_d = held_q;
		endcase
	end

	assign held_ext = 5'(held_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_line_q <= '0;
			held_q     <= '0;
		end else if (cmd.exec) begin
			held_q <= held_d;
			if (op_q == OP_START) begin
				cur_line_q <= line_q;
			end
		end
	end

	// Insert: open a gap at pos by moving the tail up one cell
	always_ff @(posedge clk) begin
		if (cmd.exec && take) begin
			for (int i = 0; i < MAX_SPRITES; i++) begin
				if (IDX_W'(i) == pos) begin
					store_q[i] <= entry_q;
				end else if ((i > 0) && (IDX_W'(i) > pos)) begin
					store_q[i] <= store_q[(i > 0) ? i - 1 : 0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			accepted_q   <= take;
			position_q   <= take ? 4'(pos) : 4'd0;
			count_q      <= held_ext[3:0];
			read_valid_q <= rd_ok;
			read_q       <= rd_entry;
		end
	end

	assign accepted   = accepted_q;
	assign position   = position_q;
	assign count      = count_q;
	assign read_valid = read_valid_q;
	assign read_y     = read_q.y;
	assign read_x     = read_q.x;
	assign read_tile  = read_q.tile;
	assign read_flags = read_q.flags;
	assign read_index = read_q.index;

endmodule

### rtl/core/scanline_sprite_selector.sv
// Top level of the scanline sprite selector: configuration register, controller
// and datapath. Depends on ssel_pkg, ssel_ctrl and ssel_dp.
//
// Builds the per-scanline sprite list. An op 0 transfer latches the line number
// and empties the list; an op 1 transfer offers one object entry, which is kept
// when its x is nonzero, the list holds fewer than MAX_SPRITES entries and the
// line lies within the sprite's 8 or 16 line span (tall_sprites, APB address
// 0). Kept entries are ordered by x, a new entry landing after any equal x, so
// offer order is preserved. An op 2 transfer reads one ordered slot. Every input
// transfer yields exactly one result transfer, which always reports count. Each
// item is handled in two steps: the first captures the transfer, the second
// compares against every held entry in parallel, shifts the tail and loads the
// result register; no new item is taken until the last has left its second
// step. A result left waiting under out_stall holds the next item in its second
// step until the result register frees.
module scanline_sprite_selector #(
	parameter int unsigned MAX_SPRITES = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  line,
	input  logic [7:0]  sprite_y,
	input  logic [7:0]  sprite_x,
	input  logic [7:0]  sprite_tile,
	input  logic [7:0]  sprite_flags,
	input  logic [5:0]  oam_index,
	input  logic [3:0]  slot,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [3:0]  position,
	output logic [3:0]  count,
	output logic        read_valid,
	output logic [7:0]  read_y,
	output logic [7:0]  read_x,
	output logic [7:0]  read_tile,
	output logic [7:0]  read_flags,
	output logic [5:0]  read_index
);
	import ssel_pkg::*;

	logic      tall_q;
	ssel_cmd_t cmd;

	// Single register at byte addresses 0 to 3 (paddr[2] low); addresses 4 to 7 read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tall_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			tall_q <= pwdata[0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {31'd0, tall_q};

	// Sequence one item at a time and gate the result register
	ssel_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Hold the ordered list, the latched line and the result payload
	ssel_dp #(
		.MAX_SPRITES (MAX_SPRITES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.tall_sprites (tall_q),
		.op           (op),
		.line         (line),
		.sprite_y     (sprite_y),
		.sprite_x     (sprite_x),
		.sprite_tile  (sprite_tile),
		.sprite_flags (sprite_flags),
		.oam_index    (oam_index),
		.slot         (slot),
		.accepted     (accepted),
		.position     (position),
		.count        (count),
		.read_valid   (read_valid),
		.read_y       (read_y),
		.read_x       (read_x),
		.read_tile    (read_tile),
		.read_flags   (read_flags),
		.read_index   (read_index)
	);

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for scanline_sprite_selector: a directed table, then random line bursts.
// Each result is checked against a shadow list or a typed row. Needs ssel_pkg and the RTL only.
module testbench;
	import ssel_pkg::*;

	// The package names three op codes; the fourth is the idle code
	localparam op_t OP_NONE = 2'd3;
	localparam int unsigned LIST_DEPTH = 10;
	localparam logic [2:0] ADDR_TALL = 3'd0;
	// Receiver hold-off used to back the block up, in cycles
	localparam int unsigned LONG_HOLD = 64;
	// Settling time after the last result, in cycles
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned PHASE_ITEMS = 175;

	typedef struct packed {
		logic       accepted;
		logic [3:0] position;
		logic [3:0] count;
		logic       read_valid;
		logic [7:0] y;
		logic [7:0] x;
		logic [7:0] tile;
		logic [7:0] flags;
		logic [5:0] idx;
	} sel_result_t;

	typedef struct {
		op_t         op;
		logic [7:0]  line;
		logic [7:0]  y;
		logic [7:0]  x;
		logic [7:0]  tile;
		logic [7:0]  flags;
		logic [5:0]  idx;
		logic [3:0]  slot;
		bit          pinned;	// use the typed result below instead of the list model
		sel_result_t want;
	} sel_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  op = '0;
	logic [7:0]  line = '0;
	logic [7:0]  sprite_y = '0;
	logic [7:0]  sprite_x = '0;
	logic [7:0]  sprite_tile = '0;
	logic [7:0]  sprite_flags = '0;
	logic [5:0]  oam_index = '0;
	logic [3:0]  slot = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        accepted;
	logic [3:0]  position;
	logic [3:0]  count;
	logic        read_valid;
	logic [7:0]  read_y;
	logic [7:0]  read_x;
	logic [7:0]  read_tile;
	logic [7:0]  read_flags;
	logic [5:0]  read_index;

	scanline_sprite_selector dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .line(line),
		.sprite_y(sprite_y), .sprite_x(sprite_x), .sprite_tile(sprite_tile),
		.sprite_flags(sprite_flags), .oam_index(oam_index), .slot(slot),
		.out_valid(out_valid), .out_stall(out_stall), .accepted(accepted),
		.position(position), .count(count), .read_valid(read_valid),
		.read_y(read_y), .read_x(read_x), .read_tile(read_tile),
		.read_flags(read_flags), .read_index(read_index)
	);

	// 12 ns period, rising edge at 6 ns
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow of the block: the sorted sprite list, its length, the latched line
	// and the height register
	entry_t      held_list [LIST_DEPTH];
	int unsigned held_n = 0;
	logic [7:0]  cur_line = '0;
	bit          tall_mode = 1'b0;

	sel_result_t pending_results [$];
	sel_item_t   cur_item;
	bit          in_fire = 1'b0;
	int unsigned fail_count = 0;
	int unsigned sent = 0;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	bit          hold_req = 1'b0;
	int unsigned hold_left = 0;

	// Apply one item to the shadow list and return the result it must produce.
	// An entry is kept when x is nonzero, the list has room and the latched line
	// lies in [y-16, y-16+height); compare without wrap so a small y still
	// covers the top lines. Equal x goes behind what is already held.
	function automatic sel_result_t sprite_list_apply(op_t o, logic [7:0] ln, logic [7:0] y,
			logic [7:0] x, logic [7:0] tl, logic [7:0] fl, logic [5:0] ix, logic [3:0] sl);
		sel_result_t r;
		int unsigned span;
		int unsigned ref_row;
		int unsigned pos;
		int unsigned k;
		r = '0;
		case (o)
			OP_START: begin
				cur_line = ln;
				held_n = 0;
			end
			OP_OFFER: begin
				span = tall_mode ? TALL_H : SHORT_H;
				ref_row = cur_line + LINE_OFFSET;
				if (x != 0 && held_n < LIST_DEPTH && y <= ref_row && ref_row < y + span) begin
					pos = 0;
					while (pos < held_n && held_list[pos].x <= x)
						pos++;
					for (k = held_n; k > pos; k--)
						held_list[k] = held_list[k - 1];
					held_list[pos] = '{y: y, x: x, tile: tl, flags: fl, index: ix};
					held_n++;
					r.accepted = 1'b1;
					r.position = pos[3:0];
				end
			end
			OP_READ: begin
				if (sl < held_n) begin
					r.read_valid = 1'b1;
					r.y = held_list[sl].y;
					r.x = held_list[sl].x;
					r.tile = held_list[sl].tile;
					r.flags = held_list[sl].flags;
					r.idx = held_list[sl].index;
				end
			end
			default: ;	// idle code: report the count only
		endcase
		r.count = held_n[3:0];
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned wantv,
			input int unsigned gotv);
		if (wantv != gotv) begin
			$error("%s: expected %0d, got %0d", name, wantv, gotv);
			fail_count++;
		end
	endtask

	// Sample both channels at the rising edge. Predict on every input transfer;
	// match every result transfer against the oldest prediction.
	always @(posedge clk) begin
		sel_result_t want;
		sel_result_t got;
		in_fire = in_valid && !in_stall;
		if (in_fire) begin
			want = sprite_list_apply(op, line, sprite_y, sprite_x, sprite_tile, sprite_flags,
				oam_index, slot);
			if (cur_item.pinned)
				want = cur_item.want;
			pending_results.push_back(want);
		end
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no prediction outstanding");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				got = '{accepted, position, count, read_valid, read_y, read_x, read_tile,
					read_flags, read_index};
				check_field("accepted", want.accepted, got.accepted);
				check_field("position", want.position, got.position);
				check_field("count", want.count, got.count);
				check_field("read_valid", want.read_valid, got.read_valid);
				check_field("read_y", want.y, got.y);
				check_field("read_x", want.x, got.x);
				check_field("read_tile", want.tile, got.tile);
				check_field("read_flags", want.flags, got.flags);
				check_field("read_index", want.idx, got.idx);
			end
		end
	end

	// Receiver: latch a long hold-off request at the rising edge, then count it
	// down on the falling edges; otherwise stall at random
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD;
		end
	end

	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Offer one item from a falling edge and hold it until its transfer
	task automatic send_item(input sel_item_t it);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		cur_item = it;
		in_valid <= 1'b1;
		op <= it.op;
		line <= it.line;
		sprite_y <= it.y;
		sprite_x <= it.x;
		sprite_tile <= it.tile;
		sprite_flags <= it.flags;
		oam_index <= it.idx;
		slot <= it.slot;
		do
			@(negedge clk);
		while (!in_fire);
		sent++;
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// Setup cycle, access cycle; the register takes the value at the rising edge in the access cycle
	task automatic write_tall(input bit value);
		repeat (DRAIN_CYCLES) @(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_TALL;
		pwdata <= {31'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tall_mode = value;
	endtask

	function automatic sel_item_t row(op_t o, int unsigned ln, int unsigned y,
			int unsigned x, int unsigned tl, int unsigned fl, int unsigned ix,
			int unsigned sl, bit pin, int unsigned acc, int unsigned pos, int unsigned cnt);
		sel_item_t it;
		it.op = o;
		it.line = ln[7:0];
		it.y = y[7:0];
		it.x = x[7:0];
		it.tile = tl[7:0];
		it.flags = fl[7:0];
		it.idx = ix[5:0];
		it.slot = sl[3:0];
		it.pinned = pin;
		it.want = '0;
		it.want.accepted = acc[0];
		it.want.position = pos[3:0];
		it.want.count = cnt[3:0];
		return it;
	endfunction

	function automatic sel_item_t random_item();
		sel_item_t it;
		it.op = op_t'($urandom_range(0, 3));
		it.line = 8'($urandom_range(0, 255));
		it.y = 8'($urandom_range(0, 255));
		it.x = 8'($urandom_range(0, 255));
		it.tile = 8'($urandom_range(0, 255));
		it.flags = 8'($urandom_range(0, 255));
		it.idx = 6'($urandom_range(0, 39));
		it.slot = 4'($urandom_range(0, 15));
		it.pinned = 1'b0;
		it.want = '0;
		return it;
	endfunction

	// One scanline's worth of traffic: a start, a run of offers that mostly
	// cover the line (with x drawn from a small pool so ties are common), reads
	// scattered in between, and the odd stray item
	task automatic send_line_burst();
		sel_item_t   it;
		int unsigned span;
		int unsigned ref_row;
		int unsigned lo;
		int unsigned hi;
		int unsigned pick;
		logic [7:0]  x_pool [4];
		it = random_item();
		it.op = OP_START;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			it.line = 8'($urandom_range(0, 7));
		else if (pick == 1)
			it.line = 8'($urandom_range(236, 255));
		send_item(it);
		span = tall_mode ? TALL_H : SHORT_H;
		ref_row = it.line + LINE_OFFSET;
		lo = ref_row - span + 1;
		hi = (ref_row > 255) ? 255 : ref_row;
		foreach (x_pool[k])
			x_pool[k] = 8'($urandom_range(1, 255));
		repeat ($urandom_range(3, 14)) begin
			it = random_item();
			it.op = OP_OFFER;
			pick = $urandom_range(0, 9);
			if (lo <= hi && pick < 7)
				it.y = 8'($urandom_range(lo, hi));
			else if (pick == 7 && lo <= 256)
				it.y = 8'(lo - 1);
			else if (pick == 8 && hi < 255)
				it.y = 8'(hi + 1);
			pick = $urandom_range(0, 11);
			if (pick == 0)
				it.x = 8'd0;
			else if (pick < 7)
				it.x = x_pool[$urandom_range(0, 3)];
			send_item(it);
			if ($urandom_range(0, 5) == 0) begin
				it = random_item();
				it.op = OP_READ;
				send_item(it);
			end
		end
		repeat ($urandom_range(1, 4)) begin
			it = random_item();
			it.op = OP_READ;
			if ($urandom_range(0, 3) != 0)
				it.slot = 4'($urandom_range(0, 10));
			send_item(it);
		end
		if ($urandom_range(0, 7) == 0)
			send_item(random_item());
	endtask

	sel_item_t directed_tab [25];

	initial begin
		int unsigned ph;
		int unsigned start_count;
		bit          paused;

		// Typed rows: after reset, the idle code, hidden and out-of-span entries,
		// reads past the end, a full list and a line that nothing can cover
		directed_tab[0]  = row(OP_READ,    0,  0,   0,   0,   0,  0,  0, 1, 0, 0, 0);
		directed_tab[1]  = row(OP_NONE,    0, 16, 255,   0,   0,  0,  0, 1, 0, 0, 0);
		directed_tab[2]  = row(OP_START,   0,  0,   0,   0,   0,  0,  0, 1, 0, 0, 0);
		directed_tab[3]  = row(OP_OFFER,   0, 16,   0, 255, 255, 39,  0, 1, 0, 0, 0);
		directed_tab[4]  = row(OP_OFFER,   0, 16, 255, 255, 255, 39,  0, 1, 1, 0, 1);
		directed_tab[5]  = row(OP_OFFER,   0,  9,   1,   0,   0,  0,  0, 1, 1, 0, 2);
		directed_tab[6]  = row(OP_OFFER,   0,  8,   5,   3,   3,  3,  0, 1, 0, 0, 2);
		directed_tab[7]  = row(OP_OFFER,   0, 17,   5,   3,   3,  3,  0, 1, 0, 0, 2);
		directed_tab[8]  = row(OP_OFFER,   0, 16, 255,   1, 128,  0,  0, 1, 1, 2, 3);
		directed_tab[9]  = row(OP_READ,    0,  0,   0,   0,   0,  0,  3, 1, 0, 0, 3);
		directed_tab[10] = row(OP_READ,    0,  0,   0,   0,   0,  0, 15, 1, 0, 0, 3);
		directed_tab[11] = row(OP_OFFER,   0, 10, 200,  17,  34,  5,  0, 0, 0, 0, 0);
		directed_tab[12] = row(OP_OFFER,   0, 11,   1,  51,  68,  6,  0, 0, 0, 0, 0);
		directed_tab[13] = row(OP_OFFER,   0, 12, 128,  85, 102, 32,  0, 0, 0, 0, 0);
		directed_tab[14] = row(OP_OFFER,   0, 13,  50, 119, 136, 16,  0, 0, 0, 0, 0);
		directed_tab[15] = row(OP_OFFER,   0, 14, 255, 153, 170,  8,  0, 0, 0, 0, 0);
		directed_tab[16] = row(OP_OFFER,   0, 15,   1, 187, 204, 31,  0, 0, 0, 0, 0);
		directed_tab[17] = row(OP_OFFER,   0, 16,   7, 221, 238, 24,  0, 0, 0, 0, 0);
		directed_tab[18] = row(OP_OFFER,   0, 16, 100,   9,   9,  9,  0, 1, 0, 0, 10);
		directed_tab[19] = row(OP_READ,    0,  0,   0,   0,   0,  0,  0, 0, 0, 0, 0);
		directed_tab[20] = row(OP_READ,    0,  0,   0,   0,   0,  0,  9, 0, 0, 0, 0);
		directed_tab[21] = row(OP_READ,    0,  0,   0,   0,   0,  0,  2, 0, 0, 0, 0);
		directed_tab[22] = row(OP_START, 255,  0,   0,   0,   0,  0,  0, 1, 0, 0, 0);
		directed_tab[23] = row(OP_OFFER,   0,255, 128,   0,   0,  0,  0, 1, 0, 0, 0);
		directed_tab[24] = row(OP_READ,    0,  0,   0,   0,   0,  0,  0, 1, 0, 0, 0);

		// Hold reset, then release it on a falling edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_tall(1'b0);

		foreach (directed_tab[i])
			send_item(directed_tab[i]);

		// Random phases: no idling, sender idle, receiver stalling, both.
		// Alternate the sprite height between phases.
		for (ph = 0; ph < 4; ph++) begin
			drain_results();
			write_tall(ph % 2 == 0);
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 58; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 58; end
				default: begin idle_pct = 12; stall_pct = 12; end
			endcase
			start_count = sent;
			paused = 1'b0;
			while (sent - start_count < PHASE_ITEMS) begin
				send_line_burst();
				if (!paused && sent - start_count > PHASE_ITEMS / 2) begin
					paused = 1'b1;
					// Phase 0 backs the block up under a long hold-off; phase 1
					// lets the sender go quiet until the pipe is empty
					if (ph == 0)
						hold_req = 1'b1;
					else if (ph == 1)
						drain_results();
				end
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

### scanline_sprite_selector.f
rtl/core/ssel_pkg.sv
rtl/core/ssel_ctrl.sv
rtl/core/ssel_dp.sv
rtl/core/scanline_sprite_selector.sv
tb/testbench.sv
